// ----- hdl/sitbl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package sitbl_pkg;

   localparam int CAPACITY = 256;
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int HELD_W = 9;
   localparam int KEY_W = 16;
   localparam int STAT_W = 16;
   localparam int KIND_W = 3;
   localparam int REQ_USER_W = 2;
   localparam int RSP_USER_W = 2;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 64;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_LOOKUP = 2'd1,
      REQ_CLEAR  = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_FOUND     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_INS_CMP,
      S_LK_PROBE,
      S_LK_CMP,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [STAT_W-1:0] strength;
      logic [STAT_W-1:0] dexterity;
      logic [STAT_W-1:0] intellect;
   } record_type;

   typedef struct packed {
      record_type       rec;
      logic [KEY_W-1:0] key;
   } entry_type;

   typedef struct packed {
      logic       load;
      logic       clear;
      logic       ins_begin;
      logic       ins_shift;
      logic       ins_place;
      logic       lk_begin;
      logic       lk_probe;
      logic       lk_low;
      logic       lk_high;
      logic       res_set;
      status_type res_code;
   } ctrl_cmd_type;

   typedef struct packed {
      req_kind_type req_kind;
      logic         key_zero;
      logic         full;
      logic         pos_zero;
      logic         probe_gt;
      logic         probe_eq;
      logic         range_empty;
   } dp_status_type;

endpackage
`default_nettype wire

// ----- hdl/sitbl_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sitbl_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire sitbl_pkg::dp_status_type dp_status,
   output sitbl_pkg::ctrl_cmd_type     cmd
);
   import sitbl_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.res_code = ST_DONE;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (dp_status.req_kind)
               REQ_INSERT: begin
                  if (dp_status.full) begin
                     cmd.res_set = 1'b1;
                     cmd.res_code = ST_FULL;
                     state_in = S_RESP;
                  end else begin
                     cmd.ins_begin = 1'b1;
                     state_in = S_INS_CMP;
                  end
               end
               REQ_LOOKUP: begin
                  if (dp_status.key_zero) begin
                     cmd.res_set = 1'b1;
                     cmd.res_code = ST_NOT_FOUND;
                     state_in = S_RESP;
                  end else begin
                     cmd.lk_begin = 1'b1;
                     state_in = S_LK_PROBE;
                  end
               end
               REQ_CLEAR: begin
                  cmd.clear = 1'b1;
                  cmd.res_set = 1'b1;
                  state_in = S_RESP;
               end
               default: begin
                  // unused request code: answer done, touch nothing
                  cmd.res_set = 1'b1;
                  state_in = S_RESP;
               end
            endcase
         end
         S_INS_CMP: begin
            if (!dp_status.pos_zero && dp_status.probe_gt) begin
               cmd.ins_shift = 1'b1;
            end else begin
               cmd.ins_place = 1'b1;
               cmd.res_set = 1'b1;
               state_in = S_RESP;
            end
         end
         S_LK_PROBE: begin
            if (dp_status.range_empty) begin
               cmd.res_set = 1'b1;
               cmd.res_code = ST_NOT_FOUND;
               state_in = S_RESP;
            end else begin
               cmd.lk_probe = 1'b1;
               state_in = S_LK_CMP;
            end
         end
         S_LK_CMP: begin
            if (dp_status.probe_eq) begin
               cmd.res_set = 1'b1;
               cmd.res_code = ST_FOUND;
               state_in = S_RESP;
            end else begin
               // probe above the key narrows from the top, else from the bottom
               cmd.lk_high = dp_status.probe_gt;
               cmd.lk_low = !dp_status.probe_gt;
               state_in = S_LK_PROBE;
            end
         end
         S_RESP: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- hdl/sitbl_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sitbl_dp (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire sitbl_pkg::entry_type    req_entry,
   input  wire sitbl_pkg::req_kind_type req_kind,
   input  wire sitbl_pkg::ctrl_cmd_type cmd,
   output sitbl_pkg::dp_status_type     dp_status,
   output sitbl_pkg::status_type        rsp_status,
   output sitbl_pkg::record_type        rsp_rec,
   output logic [sitbl_pkg::HELD_W-1:0] rsp_held
);
   import sitbl_pkg::*;

   entry_type    mem [CAPACITY];
   entry_type    rd_ff;
   entry_type    req_ff;
   req_kind_type kind_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [ADDR_W-1:0] pos_ff;
   logic [CNT_W-1:0]  low_ff;
   logic [CNT_W-1:0]  hi_ff;
   logic [ADDR_W-1:0] mid_ff;
   status_type   status_ff;
   record_type   rec_ff;

   logic [CNT_W:0]    mid_sum;
   logic [ADDR_W-1:0] mid;
   logic [ADDR_W-1:0] rd_addr;
   logic              mem_we;
   entry_type         wr_data;

   assign mid_sum = {1'b0, low_ff} + {1'b0, hi_ff} - 1'b1;
   assign mid = ADDR_W'(mid_sum >> 1);

   always_comb begin
      rd_addr = mid;
      if (cmd.ins_begin) begin
         rd_addr = ADDR_W'(count_ff - 1'b1);
      end else if (cmd.ins_shift) begin
         // fetch the word below the new position
         rd_addr = pos_ff - 1'b1 - 1'b1;
      end
   end

   assign mem_we = cmd.ins_shift | cmd.ins_place;
   assign wr_data = cmd.ins_shift ? rd_ff : req_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[pos_ff] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.clear) begin
         count_ff <= '0;
      end else if (cmd.ins_place) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_entry;
         kind_ff <= req_kind;
      end
      if (cmd.ins_begin) begin
         pos_ff <= ADDR_W'(count_ff);
      end else if (cmd.ins_shift) begin
         pos_ff <= pos_ff - 1'b1;
      end
      if (cmd.lk_begin) begin
         low_ff <= '0;
         hi_ff <= count_ff;
      end else if (cmd.lk_low) begin
         low_ff <= CNT_W'(mid_ff) + 1'b1;
      end else if (cmd.lk_high) begin
         hi_ff <= CNT_W'(mid_ff);
      end
      if (cmd.lk_probe) begin
         mid_ff <= mid;
      end
      if (cmd.res_set) begin
         status_ff <= cmd.res_code;
         rec_ff <= (cmd.res_code == ST_FOUND) ? rd_ff.rec : '0;
      end
   end

   always_comb begin
      dp_status.req_kind = kind_ff;
      dp_status.key_zero = (req_ff.key == '0);
      dp_status.full = (count_ff == CNT_W'(CAPACITY));
      dp_status.pos_zero = (pos_ff == '0);
      dp_status.probe_gt = (rd_ff.key > req_ff.key);
      dp_status.probe_eq = (rd_ff.key == req_ff.key);
      dp_status.range_empty = (low_ff >= hi_ff);
   end

   assign rsp_status = status_ff;
   assign rsp_rec = rec_ff;
   assign rsp_held = HELD_W'(count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_place_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_place |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not add one entry");

   a_shift_above_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_shift |-> !dp_status.pos_zero && !dp_status.full)
      else $error("shift at bottom slot or in full table");

   a_mid_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.lk_probe |-> (CNT_W'(mid) < hi_ff) && (CNT_W'(mid) >= low_ff))
      else $error("probe outside search range");

endmodule
`default_nettype wire

// ----- hdl/sorted_id_table_insert_search.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Sorted record table with insert, binary-search lookup and clear.
// Request words come in on req_*; req_tuser selects insert (0), lookup (1)
// or clear (2), req_tdata carries key and record. Each request gives exactly
// one response word on rsp_*: status in rsp_tuser, found record (zero unless
// found) and the number of held entries in rsp_tdata.
// One request is worked at a time; req_tready stays low from acceptance
// until the response word is taken, and the next word is taken in the cycle
// after that at the earliest.
// Steps from acceptance to rsp_tvalid: clear, full insert, unused code and
// lookup of key zero go straight from decode to the response; insert reads
// the last entry, then compares and moves down each stored entry with a
// larger key (one entry moved per cycle) before it places the new one; lookup
// runs P <= log2(count)+1 probes (read, then compare), a miss ending on an empty range.
// Worst case is an insert at the bottom of a table of 255 entries.
// Reset empties the table at once; no clearing pass. A stalled response
// holds in its output register and the block takes no new word until it
// is accepted.
module sorted_id_table_insert_search (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // key_id[15:0], kind[18:16], strength[34:19], dexterity[50:35],
   // intellect[66:51], zero pad
   input  wire logic [sitbl_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type[1:0]
   input  wire logic [sitbl_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // found_kind[2:0], found_strength[18:3], found_dexterity[34:19],
   // found_intellect[50:35], entries_held[59:51], zero pad
   output logic [sitbl_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // status[1:0]
   output logic [sitbl_pkg::RSP_USER_W-1:0]      rsp_tuser
);
   import sitbl_pkg::*;

   entry_type     req_entry;
   req_kind_type  req_kind;
   ctrl_cmd_type  cmd;
   dp_status_type dp_status;
   status_type    rsp_status;
   record_type    rsp_rec;
   logic [HELD_W-1:0] rsp_held;

   assign req_entry.key = req_tdata[15:0];
   assign req_entry.rec.kind = req_tdata[18:16];
   assign req_entry.rec.strength = req_tdata[34:19];
   assign req_entry.rec.dexterity = req_tdata[50:35];
   assign req_entry.rec.intellect = req_tdata[66:51];
   assign req_kind = req_kind_type'(req_tuser);

   sitbl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_status  (dp_status),
      .cmd        (cmd)
   );

   sitbl_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_entry  (req_entry),
      .req_kind   (req_kind),
      .cmd        (cmd),
      .dp_status  (dp_status),
      .rsp_status (rsp_status),
      .rsp_rec    (rsp_rec),
      .rsp_held   (rsp_held)
   );

   assign rsp_tdata = {4'b0, rsp_held, rsp_rec.intellect, rsp_rec.dexterity,
                       rsp_rec.strength, rsp_rec.kind};
   assign rsp_tuser = rsp_status;

endmodule
`default_nettype wire
